### rtl/core/mlnp_pkg.sv
package mlnp_pkg;

  localparam int unsigned MLNP_STACK_DEPTH = 16;

  localparam int unsigned NOTE_W = 7;
  localparam int unsigned VEL_W  = 7;
  localparam int unsigned HELD_W = 5;

  // Event kinds
  localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
  localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
  localparam logic [1:0] KIND_ALL_OFF  = 2'd2;

  typedef struct packed {
    logic capture;   // latch the incoming event, rewind pointers
    logic rm_rd;     // read stack entry at the scan pointer
    logic rm_step;   // keep or drop the entry just read
    logic sh_init;   // start the oldest-entry drop
    logic sh_rd;     // read entry for the shift
    logic sh_step;   // write it one place down
    logic push;      // write the new note on top
    logic rd_top;    // read the top entry
    logic set_top;   // take the read entry as the target
    logic clear;     // empty the stack
    logic load_out;  // fill the result register
  } mlnp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       count_zero;
    logic       full;
    logic       rm_last;
    logic       sh_last;
  } mlnp_status_t;

endpackage

### rtl/core/mlnp_dpath.sv
module mlnp_dpath import mlnp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = MLNP_STACK_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mlnp_cmd_t         cmd_i,
  output mlnp_status_t      status_o,
  input  logic              cfg_we_i,
  input  logic              cfg_legato_enable_i,
  input  logic [1:0]        kind_i,
  input  logic [NOTE_W-1:0] note_i,
  input  logic [VEL_W-1:0]  velocity_i,
  input  logic              env_active_i,
  output logic [NOTE_W-1:0] active_note_o,
  output logic              target_changed_o,
  output logic [VEL_W-1:0]  note_velocity_o,
  output logic              env_trigger_o,
  output logic              env_release_o,
  output logic              pitch_snap_o,
  output logic [HELD_W-1:0] held_count_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [NOTE_W-1:0] mem_q [STACK_DEPTH];
  logic [NOTE_W-1:0] rd_q;

  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [NOTE_W-1:0] mem_wd;
  logic              mem_re;
  logic [AW-1:0]     mem_ra;

  logic [CW-1:0]     count_q;
  logic [NOTE_W-1:0] top_q;
  logic [VEL_W-1:0]  last_vel_q;
  logic              legato_q;
  logic [AW-1:0]     r_q;
  logic [CW-1:0]     w_q;

  logic [1:0]        kind_q;
  logic [NOTE_W-1:0] note_q;
  logic [VEL_W-1:0]  vel_q;
  logic              env_q;
  logic              had_q;

  logic [CW-1:0]     top_idx;
  logic              keep;
  logic [CW-1:0]     w_next;
  logic              rm_last;

  assign top_idx = count_q - CW'(1);
  assign keep    = (rd_q != note_q);
  assign w_next  = keep ? (w_q + CW'(1)) : w_q;
  assign rm_last = ((CW'(r_q) + CW'(1)) == count_q);

  assign status_o.kind       = kind_q;
  assign status_o.count_zero = (count_q == '0);
  assign status_o.full       = (count_q == CW'(STACK_DEPTH));
  assign status_o.rm_last    = rm_last;
  assign status_o.sh_last    = (r_q == AW'(STACK_DEPTH - 1));

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = rd_q;
    mem_re = 1'b0;
    mem_ra = r_q;
    if (cmd_i.rm_rd || cmd_i.sh_rd) begin
      mem_re = 1'b1;
    end
    if (cmd_i.rd_top) begin
      mem_re = 1'b1;
      mem_ra = top_idx[AW-1:0];
    end
    if (cmd_i.rm_step) begin
      mem_we = keep;
      mem_wa = w_q[AW-1:0];
    end
    if (cmd_i.sh_step) begin
      mem_we = 1'b1;
      mem_wa = r_q - AW'(1);
    end
    if (cmd_i.push) begin
      mem_we = 1'b1;
      mem_wa = count_q[AW-1:0];
      mem_wd = note_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_ra];
    end
  end

  // Event capture; a note on at zero velocity acts as a note off
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= ((kind_i == KIND_NOTE_ON) && (velocity_i == '0)) ? KIND_NOTE_OFF : kind_i;
      note_q <= note_i;
      vel_q  <= velocity_i;
      env_q  <= env_active_i;
      had_q  <= (count_q != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      top_q      <= '0;
      last_vel_q <= '0;
      legato_q   <= 1'b1;
      r_q        <= '0;
      w_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        legato_q <= cfg_legato_enable_i;
      end
      if (cmd_i.capture) begin
        r_q <= '0;
        w_q <= '0;
      end
      if (cmd_i.rm_step) begin
        w_q <= w_next;
        r_q <= r_q + AW'(1);
        if (rm_last) begin
          count_q <= w_next;
        end
      end
      if (cmd_i.sh_init) begin
        r_q <= AW'(1);
      end
      if (cmd_i.sh_step) begin
        r_q <= r_q + AW'(1);
        if (status_o.sh_last) begin
          count_q <= CW'(STACK_DEPTH - 1);
        end
      end
      if (cmd_i.push) begin
        count_q    <= count_q + CW'(1);
        top_q      <= note_q;
        last_vel_q <= vel_q;
      end
      if (cmd_i.set_top) begin
        top_q <= rd_q;
      end
      if (cmd_i.clear) begin
        count_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      active_note_o    <= top_q;
      note_velocity_o  <= last_vel_q;
      held_count_o     <= HELD_W'(count_q);
      target_changed_o <= 1'b0;
      env_trigger_o    <= 1'b0;
      env_release_o    <= 1'b0;
      pitch_snap_o     <= 1'b0;
      case (kind_q)
        KIND_NOTE_ON: begin
          target_changed_o <= 1'b1;
          pitch_snap_o     <= !env_q;
          env_trigger_o    <= !env_q || !legato_q || !had_q;
        end
        KIND_NOTE_OFF: begin
          target_changed_o <= (count_q != '0);
          env_release_o    <= (count_q == '0);
        end
        KIND_ALL_OFF: begin
          env_release_o <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/core/mlnp_ctrl.sv
module mlnp_ctrl import mlnp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  mlnp_status_t status_i,
  output mlnp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RM_RD,
    ST_RM_CMP,
    ST_POST_RM,
    ST_SH_RD,
    ST_SH_WR,
    ST_PUSH,
    ST_TOP_RD,
    ST_TOP_WAIT,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status_i.kind)
          KIND_NOTE_ON, KIND_NOTE_OFF: begin
            state_d = status_i.count_zero ? ST_POST_RM : ST_RM_RD;
          end
          KIND_ALL_OFF: begin
            cmd_o.clear = 1'b1;
            state_d     = ST_OUT;
          end
          default: begin
            state_d = ST_OUT;
          end
        endcase
      end
      ST_RM_RD: begin
        cmd_o.rm_rd = 1'b1;
        state_d     = ST_RM_CMP;
      end
      ST_RM_CMP: begin
        cmd_o.rm_step = 1'b1;
        state_d       = status_i.rm_last ? ST_POST_RM : ST_RM_RD;
      end
      ST_POST_RM: begin
        if (status_i.kind == KIND_NOTE_ON) begin
          if (status_i.full) begin
            cmd_o.sh_init = 1'b1;
            state_d       = ST_SH_RD;
          end else begin
            state_d = ST_PUSH;
          end
        end else begin
          state_d = status_i.count_zero ? ST_OUT : ST_TOP_RD;
        end
      end
      ST_SH_RD: begin
        cmd_o.sh_rd = 1'b1;
        state_d     = ST_SH_WR;
      end
      ST_SH_WR: begin
        cmd_o.sh_step = 1'b1;
        state_d       = status_i.sh_last ? ST_PUSH : ST_SH_RD;
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = ST_OUT;
      end
      ST_TOP_RD: begin
        cmd_o.rd_top = 1'b1;
        state_d      = ST_TOP_WAIT;
      end
      ST_TOP_WAIT: begin
        cmd_o.set_top = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/mono_last_note_priority.sv
// Monophonic last-note-priority note stack with legato. Each input transfer
// is a note on, note off or all-notes-off event; each one yields exactly one
// result transfer with the target note, the latest velocity, the held count
// and the envelope/pitch strobes. The held notes live in a single-port-write,
// registered-read memory of STACK_DEPTH entries that a controller scans one
// entry at a time, dropping every copy of the event's note. A note on then
// pushes the note on top; if the stack is full and did not hold the note,
// the oldest entry is first dropped by shifting the rest down. A note off
// that leaves notes held reads the new top as the target. All-notes-off
// and the ignored kind skip the scan. A finished result waits until the
// output register is free. A new event is taken while the previous result
// still waits in the output register. The legato register (reset 1) is
// written through the cfg channel, which is always ready; write it only
// between events. The stack needs no clearing after reset.
module mono_last_note_priority import mlnp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = MLNP_STACK_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_legato_enable_i,
  // event channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        kind_i,
  input  logic [NOTE_W-1:0] note_i,
  input  logic [VEL_W-1:0]  velocity_i,
  input  logic              env_active_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [NOTE_W-1:0] active_note_o,
  output logic              target_changed_o,
  output logic [VEL_W-1:0]  note_velocity_o,
  output logic              env_trigger_o,
  output logic              env_release_o,
  output logic              pitch_snap_o,
  output logic [HELD_W-1:0] held_count_o
);

  mlnp_cmd_t    cmd;
  mlnp_status_t status;

  // Register write is a single flop update: accept every transfer at once.
  assign cfg_ready_o = 1'b1;

  // Controller: sequences the scan, the oldest-entry drop, push and top read,
  // then holds the finished result until the output register is free.
  mlnp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: note memory, count, target, velocity, legato and result flops.
  mlnp_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .cfg_we_i            (cfg_valid_i),
    .cfg_legato_enable_i (cfg_legato_enable_i),
    .kind_i              (kind_i),
    .note_i              (note_i),
    .velocity_i          (velocity_i),
    .env_active_i        (env_active_i),
    .active_note_o       (active_note_o),
    .target_changed_o    (target_changed_o),
    .note_velocity_o     (note_velocity_o),
    .env_trigger_o       (env_trigger_o),
    .env_release_o       (env_release_o),
    .pitch_snap_o        (pitch_snap_o),
    .held_count_o        (held_count_o)
  );

endmodule

### rtl/core/mlnp_chk.sv
module mlnp_chk import mlnp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [NOTE_W-1:0] active_note_o,
  input logic              target_changed_o,
  input logic              env_trigger_o,
  input logic              env_release_o,
  input logic              pitch_snap_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(active_note_o))
    else $error("result dropped or changed while stalled");

  a_trig_rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(env_trigger_o && env_release_o))
    else $error("trigger and release in one result");

  a_rel_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && env_release_o |-> !target_changed_o && !pitch_snap_o)
    else $error("release with a new target or snap");

  a_snap_trig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pitch_snap_o |-> env_trigger_o && target_changed_o)
    else $error("snap without trigger and new target");

endmodule

bind mono_last_note_priority mlnp_chk u_mlnp_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .active_note_o    (active_note_o),
  .target_changed_o (target_changed_o),
  .env_trigger_o    (env_trigger_o),
  .env_release_o    (env_release_o),
  .pitch_snap_o     (pitch_snap_o)
);

### tb/mono_last_note_priority_test.sv
`timescale 1ns / 100ps

module mono_last_note_priority_test;
  import mlnp_pkg::*;

  // Kind code the block must ignore: it reports its state with all strobes low
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  // A stall this long with no transfer on any channel means the block hung
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // Quiet cycles after the last result, to catch stray extra results
  localparam int unsigned TAIL_CYCLES = 2 * MLNP_STACK_DEPTH + 40;
  localparam int unsigned PHASE_EVENTS = 475;

  typedef struct packed {
    logic [NOTE_W-1:0] active_note;
    logic              target_changed;
    logic [VEL_W-1:0]  note_velocity;
    logic              env_trigger;
    logic              env_release;
    logic              pitch_snap;
    logic [HELD_W-1:0] held_count;
  } voice_result_t;

  // Tracks the held-note stack of the voice and queues the result that each
  // accepted event must produce.
  class held_note_tracker;
    logic [NOTE_W-1:0] held [MLNP_STACK_DEPTH];
    int unsigned       count;
    logic [VEL_W-1:0]  last_vel;
    logic [NOTE_W-1:0] target;
    logic              legato;
    voice_result_t     pending_results [$];
    int unsigned       errors;

    function new();
      count    = 0;
      last_vel = '0;
      target   = '0;
      legato   = 1'b1;
      errors   = 0;
    endfunction

    // Drop every copy of n, keep the order of the rest
    function void drop_note(logic [NOTE_W-1:0] n);
      int unsigned r;
      int unsigned w;
      w = 0;
      for (r = 0; r < count; r++) begin
        if (held[r] != n) begin
          held[w] = held[r];
          w++;
        end
      end
      count = w;
    endfunction

    function void note_event(logic [1:0] kind, logic [NOTE_W-1:0] note,
                             logic [VEL_W-1:0] vel, logic env_on);
      voice_result_t res;
      logic [1:0]    k;
      bit            had_notes;
      int unsigned   i;
      res = '0;
      k = kind;
      // zero-velocity note on is a note off
      if (k == KIND_NOTE_ON && vel == '0) k = KIND_NOTE_OFF;
      case (k)
        KIND_NOTE_ON: begin
          had_notes = (count != 0);
          drop_note(note);
          // full stack: drop the oldest entry, shift the rest down
          if (count >= MLNP_STACK_DEPTH) begin
            for (i = 1; i < MLNP_STACK_DEPTH; i++) held[i-1] = held[i];
            count = MLNP_STACK_DEPTH - 1;
          end
          held[count] = note;
          count++;
          last_vel = vel;
          target = note;
          res.target_changed = 1'b1;
          if (!env_on) begin
            res.pitch_snap  = 1'b1;
            res.env_trigger = 1'b1;
          end else if (!legato || !had_notes) begin
            res.env_trigger = 1'b1;
          end
        end
        KIND_NOTE_OFF: begin
          drop_note(note);
          if (count == 0) begin
            res.env_release = 1'b1;
          end else begin
            target = held[count-1];
            res.target_changed = 1'b1;
          end
        end
        KIND_ALL_OFF: begin
          count = 0;
          res.env_release = 1'b1;
        end
        default: ;
      endcase
      res.active_note   = target;
      res.note_velocity = last_vel;
      res.held_count    = HELD_W'(count);
      pending_results = {pending_results, res};
    endfunction

    function void report(string field, int unsigned want, int unsigned seen);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
      errors++;
    endfunction

    function void check_result(voice_result_t got);
      voice_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual note %0d held %0d",
                 $time, got.active_note, got.held_count);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.active_note !== want.active_note)
        report("active_note", want.active_note, got.active_note);
      if (got.target_changed !== want.target_changed)
        report("target_changed", want.target_changed, got.target_changed);
      if (got.note_velocity !== want.note_velocity)
        report("note_velocity", want.note_velocity, got.note_velocity);
      if (got.env_trigger !== want.env_trigger)
        report("env_trigger", want.env_trigger, got.env_trigger);
      if (got.env_release !== want.env_release)
        report("env_release", want.env_release, got.env_release);
      if (got.pitch_snap !== want.pitch_snap)
        report("pitch_snap", want.pitch_snap, got.pitch_snap);
      if (got.held_count !== want.held_count)
        report("held_count", want.held_count, got.held_count);
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic              cfg_legato_enable_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        kind_i;
  logic [NOTE_W-1:0] note_i;
  logic [VEL_W-1:0]  velocity_i;
  logic              env_active_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [NOTE_W-1:0] active_note_o;
  logic              target_changed_o;
  logic [VEL_W-1:0]  note_velocity_o;
  logic              env_trigger_o;
  logic              env_release_o;
  logic              pitch_snap_o;
  logic [HELD_W-1:0] held_count_o;

  held_note_tracker tracker;

  // Idle/stall odds in percent, and a forced receiver hold-off in cycles
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_left;
  int unsigned quiet_cycles;
  // Random notes mostly come from a narrow window so note offs hit held notes
  int unsigned note_base;

  mono_last_note_priority DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_legato_enable_i (cfg_legato_enable_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .kind_i              (kind_i),
    .note_i              (note_i),
    .velocity_i          (velocity_i),
    .env_active_i        (env_active_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .active_note_o       (active_note_o),
    .target_changed_o    (target_changed_o),
    .note_velocity_o     (note_velocity_o),
    .env_trigger_o       (env_trigger_o),
    .env_release_o       (env_release_o),
    .pitch_snap_o        (pitch_snap_o),
    .held_count_o        (held_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: stall at random, or hold off entirely while a forced
  // hold-off is counting down.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_left > 0) begin
        out_ready_i <= 1'b0;
        hold_off_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Sample between edges: inputs only move at the rising edge, outputs are
  // registered, so what is seen here is what the next edge transfers.
  initial begin
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i)
        tracker.check_result({active_note_o, target_changed_o, note_velocity_o,
                              env_trigger_o, env_release_o, pitch_snap_o,
                              held_count_o});
    end
  end

  // Watchdog: count cycles without any transfer on any channel
  initial begin
    quiet_cycles = 0;
    forever begin
      @(negedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Offer one event, optionally after an idle gap, and hold it until the
  // transfer; the expectation is noted at the accepting edge.
  task automatic send_event(input logic [1:0] kind, input logic [NOTE_W-1:0] note,
                            input logic [VEL_W-1:0] vel, input logic env_on);
    logic taken;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    note_i       <= note;
    velocity_i   <= vel;
    env_active_i <= env_on;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    tracker.note_event(kind, note, vel, env_on);
  endtask

  // Mostly playable sequences: note ons from a narrow window, note offs of
  // held notes; the rest stray offs, all-notes-off and the ignored kind.
  task automatic random_event();
    int unsigned       roll;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    roll = $urandom_range(99);
    if ($urandom_range(99) < 80)
      note = NOTE_W'(note_base + $urandom_range(23));
    else
      note = NOTE_W'($urandom_range(127));
    vel = VEL_W'($urandom_range(127));
    if (roll < 57) begin
      if ($urandom_range(99) >= 6 && vel == '0) vel = VEL_W'($urandom_range(127, 1));
      send_event(KIND_NOTE_ON, note, vel, 1'($urandom_range(1)));
    end else if (roll < 95) begin
      if (tracker.count != 0 && $urandom_range(99) < 70)
        note = tracker.held[$urandom_range(tracker.count - 1)];
      send_event(KIND_NOTE_OFF, note, vel, 1'($urandom_range(1)));
    end else if (roll < 97) begin
      send_event(KIND_ALL_OFF, note, vel, 1'($urandom_range(1)));
    end else begin
      send_event(KIND_IGNORED, note, vel, 1'($urandom_range(1)));
    end
  endtask

  // Lower valid and wait until every expected result has transferred;
  // the block is idle after that.
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_legato(input logic value);
    logic taken;
    cfg_valid_i         <= 1'b1;
    cfg_legato_enable_i <= value;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
    tracker.legato = value;
  endtask

  initial begin
    tracker             = new();
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    hold_off_left       = 0;
    note_base           = 0;
    rst_ni              = 1'b0;
    cfg_valid_i         = 1'b0;
    cfg_legato_enable_i = 1'b0;
    in_valid_i          = 1'b0;
    kind_i              = KIND_NOTE_ON;
    note_i              = '0;
    velocity_i          = '0;
    env_active_i        = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-stack offs, the ignored kind, field extremes,
    // legato re-press, zero velocity, stray offs, then overflow the stack.
    send_event(KIND_NOTE_OFF, 7'd0, 7'd0, 1'b0);
    send_event(KIND_ALL_OFF, 7'd127, 7'd127, 1'b1);
    send_event(KIND_IGNORED, 7'd127, 7'd127, 1'b1);
    send_event(KIND_NOTE_ON, 7'd0, 7'd127, 1'b0);
    send_event(KIND_NOTE_ON, 7'd127, 7'd1, 1'b1);
    send_event(KIND_NOTE_ON, 7'd127, 7'd64, 1'b1);
    send_event(KIND_NOTE_ON, 7'd60, 7'd0, 1'b1);
    send_event(KIND_NOTE_OFF, 7'd0, 7'd33, 1'b1);
    send_event(KIND_NOTE_OFF, 7'd127, 7'd0, 1'b0);
    send_event(KIND_NOTE_ON, 7'd5, 7'd90, 1'b1);
    for (int i = 0; i < MLNP_STACK_DEPTH; i++)
      send_event(KIND_NOTE_ON, NOTE_W'(10 + i), VEL_W'(8 * i + 3), 1'($urandom_range(1)));
    // the oldest note was pushed out, so this off only retargets
    send_event(KIND_NOTE_OFF, 7'd5, 7'd9, 1'b1);
    send_event(KIND_ALL_OFF, 7'd0, 7'd0, 1'b0);

    // Random phases: no idling, sender idle, receiver stalling, both
    for (int p = 0; p < 4; p++) begin
      wait_all_results();
      write_legato(p % 2 == 1);
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      note_base = $urandom_range(104);
      repeat (PHASE_EVENTS) random_event();
    end

    // Hold the result side off while events keep coming, so the block
    // fills up and stalls its input.
    wait_all_results();
    write_legato(1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 300;
    repeat (40) random_event();

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
